// ===== rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types, codes and sizes for the indexed sequence list.
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;

  // Count must be able to hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Compare width covers both the 6-bit position and the count
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
  // Read tree grouping
  localparam int GROUP   = 8;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic [2:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_REM_AT    = 3'd4,
    CMD_GET       = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_INDEX = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_TAKE_LOWER = 2'd1,
    OP_TAKE_UPPER = 2'd2,
    OP_LOAD       = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     rd_sel;
  } cell_ctrl_t;

endpackage

// ===== rtl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: holds a handle, shifts towards either neighbour or loads.
// ----------------------------------------------------------------------------
module isl_cell
  import isl_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  handle_t    lower_i,   // neighbour towards the front
  input  handle_t    upper_i,   // neighbour towards the back
  input  handle_t    handle_i,
  output handle_t    data_o,
  output handle_t    rd_o
);

  handle_t data_q, data_d;

  always_comb begin
    case (ctrl_i.op)
      OP_TAKE_LOWER: data_d = lower_i;
      OP_TAKE_UPPER: data_d = upper_i;
      OP_LOAD:       data_d = handle_i;
      default:       data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // masked read tap, OR-combined downstream
  assign rd_o   = ctrl_i.rd_sel ? data_q : '0;

endmodule

// ===== rtl/isl_read_tree.sv =====
// ----------------------------------------------------------------------------
// isl_read_tree
// Registered OR tree that collects the one selected cell tap.
// ----------------------------------------------------------------------------
module isl_read_tree
  import isl_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  handle_t taps_i [CAPACITY],
  output handle_t value_o
);

  handle_t grp_q [NGROUPS];
  handle_t grp_d [NGROUPS];

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | taps_i[g * GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    value_o = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      value_o = value_o | grp_q[g];
    end
  end

endmodule

// ===== rtl/indexed_sequence_list.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_list
// Bounded ordered list of handles built as a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command transaction:
//   cmd_i, position_i, handle_i. Output channel (out_valid_o/out_ready_i)
//   returns exactly one result transaction per command: read_value_o,
//   status_o and length_o (entry count after the command).
//   The list lives in a row of CAPACITY cells, entry 0 at the front. At the
//   accepting edge every cell shifts towards a neighbour, loads the new
//   handle or holds, all in parallel, so an insert or removal completes there.
//   A get drives the addressed cell onto a two-level registered OR tree.
//   The result is valid after the tree register, then the output register;
//   one command is in flight at a time.
//   A new command is taken in the cycle its predecessor's result is taken,
//   so the output register decouples the two sides.
//   If the receiver stalls, the result holds and no further command is
//   accepted until it is taken.
//   Reset empties the list and clears both handshakes; cell contents are
//   not cleared (never read until written).
// ----------------------------------------------------------------------------
module indexed_sequence_list
  import isl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] handle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [6:0]  length_o
);

  // control state
  logic             busy_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] count_q, count_d;

  // per-transaction staging
  status_e          st_q, st_d;
  logic [CNT_W-1:0] len_q;
  handle_t          rdv_q;
  status_e          ost_q;
  logic [CNT_W-1:0] olen_q;

  logic             accept;
  cmd_e             cmd;
  handle_t          h;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             full, empty, bad_idx;

  cell_ctrl_t       ctrl  [CAPACITY];
  handle_t          cdata [CAPACITY];
  handle_t          taps  [CAPACITY];
  handle_t          tree_value;

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(cmd_i);
  assign h          = HANDLE_BITS'(handle_i);

  assign pos_x   = CMP_W'(position_i);
  assign cnt_x   = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign bad_idx = (pos_x >= cnt_x);

  // Status and new count
  always_comb begin
    st_d    = ST_OK;
    count_d = count_q;
    unique case (cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK: begin
        if (full) st_d = ST_FULL;
        else      count_d = count_q + 1'b1;
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (empty) st_d = ST_EMPTY;
        else       count_d = count_q - 1'b1;
      end
      CMD_REM_AT: begin
        if (bad_idx) st_d = ST_INDEX;
        else         count_d = count_q - 1'b1;
      end
      CMD_GET: begin
        if (bad_idx) st_d = ST_INDEX;
      end
      CMD_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  // Per-cell control: each cell compares its own slot with count / position
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].op     = OP_HOLD;
      ctrl[i].rd_sel = 1'b0;
      if (accept) begin
        case (cmd)
          CMD_ADD_FRONT: begin
            if (!full) ctrl[i].op = OP_TAKE_LOWER;
          end
          CMD_ADD_BACK: begin
            if (!full && CMP_W'(i) == cnt_x) ctrl[i].op = OP_LOAD;
          end
          CMD_REM_FRONT: begin
            if (!empty) ctrl[i].op = OP_TAKE_UPPER;
          end
          CMD_REM_AT: begin
            if (!bad_idx && CMP_W'(i) >= pos_x) ctrl[i].op = OP_TAKE_UPPER;
          end
          CMD_GET: begin
            ctrl[i].rd_sel = !bad_idx && (CMP_W'(i) == pos_x);
          end
          default: ;
        endcase
      end
    end
  end

  // The chain: front cell's lower neighbour is the incoming handle,
  // back cell's upper neighbour is itself
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    isl_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[i]),
      .lower_i  ((i == 0) ? h : cdata[(i == 0) ? 0 : i - 1]),
      .upper_i  (cdata[(i == CAPACITY - 1) ? i : i + 1]),
      .handle_i (h),
      .data_o   (cdata[i]),
      .rd_o     (taps[i])
    );
  end

  isl_read_tree u_tree (
    .clk_i   (clk_i),
    .en_i    (accept),
    .taps_i  (taps),
    .value_o (tree_value)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q <= accept;
      if (accept) count_q <= count_d;
      if (busy_q)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q  <= st_d;
      len_q <= count_d;
    end
    if (busy_q) begin
      rdv_q  <= tree_value;
      ost_q  <= st_q;
      olen_q <= len_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = 32'(rdv_q);
  assign status_o     = ost_q;
  assign length_o     = 7'(olen_q);

endmodule
